/* sv/jfe_pkg.sv */
// shared types, constants and helpers for the joystick frame encoder
`default_nettype none

package jfe_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int RANGE_BITS  = 4 * SAMPLE_BITS;
    localparam int FULL_SCALE  = 1 << SAMPLE_BITS;

    // stream beat widths: six samples in, keys plus four axes out, byte padded
    localparam int S_TDATA_W = ((6 * SAMPLE_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W = 48;

    // quotient bits and divider cut
    localparam int Q_W                = 9;
    localparam int DIV_BITS_PER_STAGE = 3;
    localparam int DIV_STAGES         = Q_W / DIV_BITS_PER_STAGE;

    // numerator holds 400 * (full scale - 1), divisor shifted by Q_W - 1
    localparam int NUM_W = SAMPLE_BITS + 9;

    localparam logic [NUM_W-1:0] SCALE_SYM = NUM_W'(200);
    localparam logic [NUM_W-1:0] SCALE_ONE = NUM_W'(400);

    // register indexes
    localparam logic [1:0] CFG_LEFT_X  = 2'd0;
    localparam logic [1:0] CFG_LEFT_Y  = 2'd1;
    localparam logic [1:0] CFG_RIGHT_X = 2'd2;
    localparam logic [1:0] CFG_RIGHT_Y = 2'd3;

    // key ladder thresholds in eighths of full scale
    localparam logic [SAMPLE_BITS:0] KEY_T1 = (SAMPLE_BITS + 1)'(FULL_SCALE * 1 / 8);
    localparam logic [SAMPLE_BITS:0] KEY_T3 = (SAMPLE_BITS + 1)'(FULL_SCALE * 3 / 8);
    localparam logic [SAMPLE_BITS:0] KEY_T5 = (SAMPLE_BITS + 1)'(FULL_SCALE * 5 / 8);
    localparam logic [SAMPLE_BITS:0] KEY_T7 = (SAMPLE_BITS + 1)'(FULL_SCALE * 7 / 8);

    localparam logic [3:0] KEY_CODE_0    = 4'h1;
    localparam logic [3:0] KEY_CODE_1    = 4'h2;
    localparam logic [3:0] KEY_CODE_2    = 4'h4;
    localparam logic [3:0] KEY_CODE_3    = 4'h8;
    localparam logic [3:0] KEY_CODE_NONE = 4'h0;

    typedef enum logic [2:0] {
        SEG_NEG_FULL,
        SEG_NEG_LIN,
        SEG_ZERO,
        SEG_POS_LIN,
        SEG_POS_FULL
    } seg_t;

    typedef struct packed {
        seg_t seg;
        logic wide;     // one-sided mapping, full scale is 400
    } axis_ctl_t;

    typedef struct packed {
        logic [NUM_W-1:0] rem;
        logic [NUM_W-1:0] den_sh;
        logic [Q_W-1:0]   quo;
        axis_ctl_t        ctl;
    } div_word_t;

    // packs four thresholds the way the calibration table lists them
    function automatic logic [RANGE_BITS-1:0] pack4(longint unsigned a, longint unsigned b,
                                                    longint unsigned c, longint unsigned d);
        logic [63:0] w;
        w = 64'(a) | (64'(b) << SAMPLE_BITS) | (64'(c) << (2 * SAMPLE_BITS))
            | (64'(d) << (3 * SAMPLE_BITS));
        return w[RANGE_BITS-1:0];
    endfunction

    localparam logic [RANGE_BITS-1:0] LEFT_X_RESET  = pack4(460, 1700, 1900, 3500);
    localparam logic [RANGE_BITS-1:0] LEFT_Y_RESET  = pack4(550, 2000, 2100, 3650);
    localparam logic [RANGE_BITS-1:0] RIGHT_X_RESET = pack4(600, 1920, 2120, 3620);
    localparam logic [RANGE_BITS-1:0] RIGHT_Y_RESET = pack4(420, 1900, 2100, 3500);

    function automatic logic [3:0] key_nibble(logic [SAMPLE_BITS-1:0] v);
        logic [SAMPLE_BITS:0] x;
        x = {1'b0, v};
        if (x < KEY_T1) begin
            return KEY_CODE_0;
        end else if (x < KEY_T3) begin
            return KEY_CODE_1;
        end else if (x < KEY_T5) begin
            return KEY_CODE_2;
        end else if (x < KEY_T7) begin
            return KEY_CODE_3;
        end else begin
            return KEY_CODE_NONE;
        end
    endfunction

endpackage

`default_nettype wire

/* sv/joystick_frame_encoder.sv */
// top level: joystick scan to control frame encoder
//
//   channel | dir | beat contents
//   --------+-----+----------------------------------------------------------
//   s_      | in  | six 12-bit adc samples in tdata, recenter flag in tuser
//   m_      | out | keys and four scaled axes in tdata, recenter copy in tuser
//   cfg_    | in  | write-only calibration thresholds, one 48-bit word each
//
// one beat enters per cycle unless the output stalls; in order, a frame passes the
// front stage, three divider stages of three quotient bits each, output register
// the divider stage count is set by the 9-bit quotient of the ramp division
// reset restores the default calibration and empties the pipeline
// the whole pipeline holds while the output register is full and not taken
`default_nettype none

module joystick_frame_encoder import jfe_pkg::*; (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,

    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    // left_x_sample, left_y_sample, right_x_sample, right_y_sample,
    // key_low_sample, key_high_sample
    input  wire logic [S_TDATA_W-1:0]      s_tdata,
    // recenter_flag
    input  wire logic                      s_tuser,

    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    // key_bits, left_x_value, left_y_value, right_x_value, right_y_value, zero fill
    output logic [M_TDATA_W-1:0]           m_tdata,
    // recenter_out
    output logic                           m_tuser,

    input  wire logic                      cfg_we,
    input  wire logic [1:0]                cfg_addr,
    input  wire logic [RANGE_BITS-1:0]     cfg_wdata
);

    localparam int AXW       = 9;   // symmetric axis field
    localparam int LYW       = 10;  // left y field
    localparam int NUM_AXES  = 4;
    localparam int AX_LX     = 0;
    localparam int AX_LY     = 1;
    localparam int AX_RX     = 2;
    localparam int AX_RY     = 3;

    // calibration registers
    logic [RANGE_BITS-1:0] left_x_range_reg;
    logic [RANGE_BITS-1:0] left_y_range_reg;
    logic [RANGE_BITS-1:0] right_x_range_reg;
    logic [RANGE_BITS-1:0] right_y_range_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_x_range_reg  <= LEFT_X_RESET;
            left_y_range_reg  <= LEFT_Y_RESET;
            right_x_range_reg <= RIGHT_X_RESET;
            right_y_range_reg <= RIGHT_Y_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_LEFT_X:  left_x_range_reg  <= cfg_wdata;
                CFG_LEFT_Y:  left_y_range_reg  <= cfg_wdata;
                CFG_RIGHT_X: right_x_range_reg <= cfg_wdata;
                CFG_RIGHT_Y: right_y_range_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // global advance: every stage moves when the output slot is free or drained
    logic advance;
    assign advance  = !m_tvalid || m_tready;
    assign s_tready = advance;

    logic accept;
    assign accept = s_tvalid && s_tready;

    // input unpacking
    logic [SAMPLE_BITS-1:0] samp [NUM_AXES];
    logic [SAMPLE_BITS-1:0] key_lo_samp;
    logic [SAMPLE_BITS-1:0] key_hi_samp;
    logic [RANGE_BITS-1:0]  axis_range [NUM_AXES];
    logic                   axis_one_sided [NUM_AXES];

    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            samp[a] = s_tdata[a*SAMPLE_BITS +: SAMPLE_BITS];
        end
        key_lo_samp = s_tdata[4*SAMPLE_BITS +: SAMPLE_BITS];
        key_hi_samp = s_tdata[5*SAMPLE_BITS +: SAMPLE_BITS];
        axis_range[AX_LX] = left_x_range_reg;
        axis_range[AX_LY] = left_y_range_reg;
        axis_range[AX_RX] = right_x_range_reg;
        axis_range[AX_RY] = right_y_range_reg;
        axis_one_sided[AX_LX] = 1'b0;
        axis_one_sided[AX_LY] = !s_tuser;  // left y without recentering is 0..400
        axis_one_sided[AX_RX] = 1'b0;
        axis_one_sided[AX_RY] = 1'b0;
    end

    // per-axis datapath: front stage, then the divider slices
    div_word_t pipe [NUM_AXES][DIV_STAGES+1];

    for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
        jfe_axis_front u_front (
            .aclk      (aclk),
            .en        (advance),
            .sample    (samp[a]),
            .range_cfg (axis_range[a]),
            .one_sided (axis_one_sided[a]),
            .word_reg  (pipe[a][0])
        );
        for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
            jfe_div_stage u_div (
                .aclk     (aclk),
                .en       (advance),
                .word_in  (pipe[a][k]),
                .word_reg (pipe[a][k+1])
            );
        end
    end

    // key byte: two nibbles with at most one bit set each, bits 6 and 7 exchanged
    logic [7:0] keys_raw;
    logic [7:0] keys_swapped;
    assign keys_raw     = {key_nibble(key_hi_samp), key_nibble(key_lo_samp)};
    assign keys_swapped = {keys_raw[6], keys_raw[7], keys_raw[5:0]};

    // sideband and valid bits ride alongside the axis pipeline
    logic [DIV_STAGES:0] vld_reg;
    logic [7:0]          keys_reg [DIV_STAGES+1];
    logic                rec_reg  [DIV_STAGES+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (advance) begin
            vld_reg <= {vld_reg[DIV_STAGES-1:0], accept};
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            keys_reg[0] <= keys_swapped;
            rec_reg[0]  <= s_tuser;
            for (int k = 1; k <= DIV_STAGES; k++) begin
                keys_reg[k] <= keys_reg[k-1];
                rec_reg[k]  <= rec_reg[k-1];
            end
        end
    end

    // final value from segment and quotient, signed 10 bits
    function automatic logic signed [LYW-1:0] axis_value(div_word_t w);
        logic signed [LYW-1:0] q;
        q = LYW'($signed({1'b0, w.quo}));
        case (w.ctl.seg)
            SEG_NEG_FULL: return -LYW'(200);
            SEG_NEG_LIN:  return -q;
            SEG_ZERO:     return '0;
            SEG_POS_LIN:  return q;
            SEG_POS_FULL: return w.ctl.wide ? LYW'(400) : LYW'(200);
            default:      return '0;
        endcase
    endfunction

    logic signed [LYW-1:0] lx_full, ly_full, rx_full, ry_full;
    assign lx_full = axis_value(pipe[AX_LX][DIV_STAGES]);
    assign ly_full = axis_value(pipe[AX_LY][DIV_STAGES]);
    assign rx_full = axis_value(pipe[AX_RX][DIV_STAGES]);
    assign ry_full = axis_value(pipe[AX_RY][DIV_STAGES]);

    // output register
    logic                  out_vld_reg;
    logic [7:0]            keys_out_reg;
    logic                  rec_out_reg;
    logic signed [AXW-1:0] lx_reg, rx_reg, ry_reg;
    logic signed [LYW-1:0] ly_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (advance) begin
            out_vld_reg <= vld_reg[DIV_STAGES];
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            keys_out_reg <= keys_reg[DIV_STAGES];
            rec_out_reg  <= rec_reg[DIV_STAGES];
            lx_reg       <= AXW'(-lx_full);   // left x is mirrored
            ly_reg       <= ly_full;
            rx_reg       <= AXW'(rx_full);
            ry_reg       <= AXW'(-ry_full);   // right y is mirrored
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tuser  = rec_out_reg;
    assign m_tdata  = {3'b000, ry_reg, rx_reg, ly_reg, lx_reg, keys_out_reg};

endmodule

`default_nettype wire

/* sv/jfe_axis_front.sv */
// axis front stage: segment select, scaled numerator and divisor setup
`default_nettype none

module jfe_axis_front import jfe_pkg::*; (
    input  wire logic                   aclk,
    input  wire logic                   en,
    input  wire logic [SAMPLE_BITS-1:0] sample,
    input  wire logic [RANGE_BITS-1:0]  range_cfg,
    input  wire logic                   one_sided,
    output div_word_t                   word_reg
);

    logic [SAMPLE_BITS-1:0] r0, r1, r2, r3;
    logic [SAMPLE_BITS-1:0] diff;
    logic [SAMPLE_BITS-1:0] den;
    logic [NUM_W-1:0]       scale;
    div_word_t              word_next;

    assign r0 = range_cfg[0*SAMPLE_BITS +: SAMPLE_BITS];
    assign r1 = range_cfg[1*SAMPLE_BITS +: SAMPLE_BITS];
    assign r2 = range_cfg[2*SAMPLE_BITS +: SAMPLE_BITS];
    assign r3 = range_cfg[3*SAMPLE_BITS +: SAMPLE_BITS];

    always_comb begin
        diff  = '0;
        den   = '0;
        scale = SCALE_SYM;
        word_next.ctl.wide = one_sided;
        if (one_sided) begin
            scale = SCALE_ONE;
            if (sample <= r0) begin
                word_next.ctl.seg = SEG_ZERO;
            end else if (sample < r3) begin
                word_next.ctl.seg = SEG_POS_LIN;
                diff = sample - r0;
                den  = r3 - r0;
            end else begin
                word_next.ctl.seg = SEG_POS_FULL;
            end
        end else begin
            if (sample <= r0) begin
                word_next.ctl.seg = SEG_NEG_FULL;
            end else if (sample < r1) begin
                // magnitude of the lower ramp, sign applied at the output
                word_next.ctl.seg = SEG_NEG_LIN;
                diff = r1 - sample;
                den  = r1 - r0;
            end else if (sample <= r2) begin
                word_next.ctl.seg = SEG_ZERO;
            end else if (sample < r3) begin
                word_next.ctl.seg = SEG_POS_LIN;
                diff = sample - r2;
                den  = r3 - r2;
            end else begin
                word_next.ctl.seg = SEG_POS_FULL;
            end
        end
        word_next.rem    = NUM_W'(diff) * scale;
        word_next.den_sh = NUM_W'(den) << (Q_W - 1);
        word_next.quo    = '0;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            word_reg <= word_next;
        end
    end

endmodule

`default_nettype wire

/* sv/jfe_div_stage.sv */
// one slice of the restoring divider, DIV_BITS_PER_STAGE quotient bits per stage
`default_nettype none

module jfe_div_stage import jfe_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       en,
    input  wire div_word_t  word_in,
    output div_word_t       word_reg
);

    div_word_t word_next;

    always_comb begin
        word_next = word_in;
        for (int i = 0; i < DIV_BITS_PER_STAGE; i++) begin
            if (word_next.rem >= word_next.den_sh) begin
                word_next.rem = word_next.rem - word_next.den_sh;
                word_next.quo = {word_next.quo[Q_W-2:0], 1'b1};
            end else begin
                word_next.quo = {word_next.quo[Q_W-2:0], 1'b0};
            end
            word_next.den_sh = word_next.den_sh >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            word_reg <= word_next;
        end
    end

endmodule

`default_nettype wire

/* sv/jfe_checker.sv */
// port-level checks for the joystick frame encoder, bound to the top level
`default_nettype none

module jfe_checker import jfe_pkg::*; (
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [M_TDATA_W-1:0]  m_tdata,
    input wire logic                  m_tuser
);

    // pipeline comes out of reset empty
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("frame valid right after reset");

    // a stalled frame holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled frame changed");

    // left x stays inside full scale
    a_lx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[16:8]) >= -9'sd200)
                  && ($signed(m_tdata[16:8]) <= 9'sd200))
        else $error("left x out of range");

    // each key nibble holds at most one pressed key, high nibble after the swap
    a_key_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $onehot0(m_tdata[3:0])
                  && $onehot0({m_tdata[6], m_tdata[7], m_tdata[5:4]}))
        else $error("key nibble not one-hot");

    // without recentering left y never goes negative
    a_ly_one_sided: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> !m_tdata[26])
        else $error("negative left y in one-sided mode");

endmodule

bind joystick_frame_encoder jfe_checker u_jfe_checker (.*);

`default_nettype wire
